>>> hdl/ehd_pkg.sv
// ----------------------------------------------------------------------------
// ehd_pkg
// Shared types and constants for the EMA hit detector with hysteresis.
// ----------------------------------------------------------------------------
package ehd_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 12;
  localparam int EMA_FRAC_BITS_DEF = 8;
  localparam int HOLD_WIDTH_DEF    = 8;

  localparam int ALPHA_W    = 9;
  localparam int COUNT_W    = 12;
  localparam int REFRACT_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int MODE_W     = 2;

  localparam int ALPHA_SHIFT = 8;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

  localparam logic [ALPHA_W-1:0]   ALPHA_RESET    = 9'd77;
  localparam logic [COUNT_W-1:0]   BASELINE_RESET = 12'd120;
  localparam logic [COUNT_W-1:0]   FIRE_RESET     = 12'd270;
  localparam logic [COUNT_W-1:0]   RELEASE_RESET  = 12'd120;
  localparam logic [REFRACT_W-1:0] REFRACT_RESET  = 8'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA,
    REG_BASELINE,
    REG_FIRE,
    REG_RELEASE,
    REG_REFRACT
  } reg_index_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE,
    MODE_ARMED,
    MODE_REFRACT
  } mode_t;

  typedef struct packed {
    logic [ALPHA_W-1:0]   alpha_q8;
    logic [COUNT_W-1:0]   baseline_counts;
    logic [COUNT_W-1:0]   fire_counts;
    logic [COUNT_W-1:0]   release_counts;
    logic [REFRACT_W-1:0] refractory_samples;
  } cfg_t;

endpackage

>>> hdl/ehd_cfg.sv
// ----------------------------------------------------------------------------
// ehd_cfg
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module ehd_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            we,
  input  logic [ehd_pkg::CFG_IDX_W-1:0]   index,
  input  logic [ehd_pkg::CFG_DATA_W-1:0]  data,
  output ehd_pkg::cfg_t                   cfg
);
  import ehd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha_q8           <= ALPHA_RESET;
      cfg.baseline_counts    <= BASELINE_RESET;
      cfg.fire_counts        <= FIRE_RESET;
      cfg.release_counts     <= RELEASE_RESET;
      cfg.refractory_samples <= REFRACT_RESET;
    end else if (we) begin
      case (index)
        REG_ALPHA:    cfg.alpha_q8           <= data[ALPHA_W-1:0];
        REG_BASELINE: cfg.baseline_counts    <= data[COUNT_W-1:0];
        REG_FIRE:     cfg.fire_counts        <= data[COUNT_W-1:0];
        REG_RELEASE:  cfg.release_counts     <= data[COUNT_W-1:0];
        REG_REFRACT:  cfg.refractory_samples <= data[REFRACT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/ehd_ema.sv
// ----------------------------------------------------------------------------
// ehd_ema
// Exponential moving average state and the clamped level above baseline.
// ----------------------------------------------------------------------------
module ehd_ema #(
  parameter int SAMPLE_WIDTH  = ehd_pkg::SAMPLE_WIDTH_DEF,
  parameter int EMA_FRAC_BITS = ehd_pkg::EMA_FRAC_BITS_DEF,
  parameter int LEVEL_W       = ehd_pkg::COUNT_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [SAMPLE_WIDTH-1:0]       sample,
  input  logic [ehd_pkg::ALPHA_W-1:0]   alpha_q8,
  input  logic [ehd_pkg::COUNT_W-1:0]   baseline_counts,
  output logic [LEVEL_W-1:0]            level
);
  import ehd_pkg::*;

  localparam int W  = SAMPLE_WIDTH + EMA_FRAC_BITS;
  localparam int PW = W + ALPHA_W + 2;

  logic [W-1:0]         ema_value;
  logic [W-1:0]         ema_value_next;
  logic [ALPHA_W-1:0]   alpha_sat;
  logic signed [W:0]    diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rounded;
  logic [SAMPLE_WIDTH-1:0] whole;
  logic [LEVEL_W-1:0]   whole_ext;
  logic [LEVEL_W-1:0]   base_ext;

  // The update a*s + (256-a)*e equals 256*e + a*(s-e), so one product suffices.
  always_comb begin
    alpha_sat      = (alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : alpha_q8;
    diff           = $signed({1'b0, sample, {EMA_FRAC_BITS{1'b0}}})
                   - $signed({1'b0, ema_value});
    prod           = $signed({1'b0, alpha_sat}) * diff;
    rounded        = (prod + PW'(signed'(1 <<< (ALPHA_SHIFT - 1)))) >>> ALPHA_SHIFT;
    ema_value_next = ema_value + rounded[W-1:0];
    whole          = ema_value_next[W-1:EMA_FRAC_BITS];
    whole_ext      = LEVEL_W'(whole);
    base_ext       = LEVEL_W'(baseline_counts);
    level          = (whole_ext > base_ext) ? (whole_ext - base_ext) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ema_value <= {SAMPLE_WIDTH'(BASELINE_RESET), {EMA_FRAC_BITS{1'b0}}};
    end else if (en) begin
      ema_value <= ema_value_next;
    end
  end

endmodule

>>> hdl/ehd_detect.sv
// ----------------------------------------------------------------------------
// ehd_detect
// Three-state hit detector with hysteresis and a refractory hold count.
// ----------------------------------------------------------------------------
module ehd_detect #(
  parameter int HOLD_WIDTH = ehd_pkg::HOLD_WIDTH_DEF,
  parameter int LEVEL_W    = ehd_pkg::COUNT_W
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [LEVEL_W-1:0]              level,
  input  logic [ehd_pkg::COUNT_W-1:0]     fire_counts,
  input  logic [ehd_pkg::COUNT_W-1:0]     release_counts,
  input  logic [ehd_pkg::REFRACT_W-1:0]   refractory_samples,
  output logic                            hit,
  output ehd_pkg::mode_t                  mode_next
);
  import ehd_pkg::*;

  localparam int CMP_W = (HOLD_WIDTH > REFRACT_W ? HOLD_WIDTH : REFRACT_W) + 1;
  localparam logic [CMP_W-1:0] HOLD_MAX = CMP_W'((1 << HOLD_WIDTH) - 1);

  mode_t                 mode;
  logic [HOLD_WIDTH-1:0] hold_count;
  logic [HOLD_WIDTH-1:0] hold_count_next;
  logic [HOLD_WIDTH-1:0] hold_load;
  logic [HOLD_WIDTH-1:0] hold_dec;
  logic                  fire_hit;
  logic                  release_ok;

  always_comb begin
    fire_hit   = level >= LEVEL_W'(fire_counts);
    release_ok = level < LEVEL_W'(release_counts);
    hold_dec   = (hold_count != '0) ? hold_count - 1'b1 : '0;
    if (CMP_W'(refractory_samples) > HOLD_MAX) begin
      hold_load = HOLD_MAX[HOLD_WIDTH-1:0];
    end else begin
      hold_load = HOLD_WIDTH'(refractory_samples);
    end
  end

  always_comb begin
    case (mode)
      MODE_ARMED: begin
        mode_next = (hold_dec == '0 && release_ok) ? MODE_REFRACT : MODE_ARMED;
      end
      MODE_REFRACT: begin
        mode_next = MODE_IDLE;
      end
      default: begin
        mode_next = fire_hit ? MODE_ARMED : MODE_IDLE;
      end
    endcase
  end

  always_comb begin
    case (mode)
      MODE_ARMED: begin
        hit             = 1'b0;
        hold_count_next = hold_dec;
      end
      MODE_REFRACT: begin
        hit             = 1'b0;
        hold_count_next = hold_count;
      end
      default: begin
        hit             = fire_hit;
        hold_count_next = fire_hit ? hold_load : hold_count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      hold_count <= '0;
    end else if (en) begin
      mode       <= mode_next;
      hold_count <= hold_count_next;
    end
  end

endmodule

>>> hdl/ema_hit_detector_hysteresis_unit.sv
// ----------------------------------------------------------------------------
// ema_hit_detector_hysteresis_unit
// Smooths force-sensor samples and flags hits with hysteresis.
//
//   channel   direction   handshake            payload
//   in        input       in_valid / in_stall   sample
//   out       output      out_valid / out_stall hit, filtered_level,
//                                               detector_mode
//   cfg       input       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One sample is taken per cycle while the result side does not stall; each
// sample is held in the input register and its result in the result
// register. The EMA product and the detector compare are both combinational
// between the input register and the result register.
// Reset clears the pipeline, loads the EMA with the reset baseline and
// returns the detector to idle. A stalled result holds the pipeline and
// stalls the input once the input register is also full.
// ----------------------------------------------------------------------------
module ema_hit_detector_hysteresis_unit #(
  parameter int SAMPLE_WIDTH  = ehd_pkg::SAMPLE_WIDTH_DEF,
  parameter int EMA_FRAC_BITS = ehd_pkg::EMA_FRAC_BITS_DEF,
  parameter int HOLD_WIDTH    = ehd_pkg::HOLD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [SAMPLE_WIDTH-1:0]         sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            hit,
  output logic [ehd_pkg::COUNT_W-1:0]     filtered_level,
  output logic [ehd_pkg::MODE_W-1:0]      detector_mode,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ehd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ehd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ehd_pkg::*;

  localparam int LEVEL_W = (SAMPLE_WIDTH > COUNT_W) ? SAMPLE_WIDTH : COUNT_W;

  cfg_t                    cfg;
  logic                    stage_valid;
  logic [SAMPLE_WIDTH-1:0] stage_sample;
  logic                    advance;
  logic [LEVEL_W-1:0]      level;
  logic                    hit_next;
  mode_t                   mode_next;

  assign cfg_ready = 1'b1;
  assign advance   = stage_valid && (!out_valid || !out_stall);
  assign in_stall  = stage_valid && !advance;

  ehd_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_valid && cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  ehd_ema #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .EMA_FRAC_BITS (EMA_FRAC_BITS),
    .LEVEL_W       (LEVEL_W)
  ) u_ema (
    .clk             (clk),
    .rst             (rst),
    .en              (advance),
    .sample          (stage_sample),
    .alpha_q8        (cfg.alpha_q8),
    .baseline_counts (cfg.baseline_counts),
    .level           (level)
  );

  ehd_detect #(
    .HOLD_WIDTH (HOLD_WIDTH),
    .LEVEL_W    (LEVEL_W)
  ) u_detect (
    .clk                (clk),
    .rst                (rst),
    .en                 (advance),
    .level              (level),
    .fire_counts        (cfg.fire_counts),
    .release_counts     (cfg.release_counts),
    .refractory_samples (cfg.refractory_samples),
    .hit                (hit_next),
    .mode_next          (mode_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_sample <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit            <= hit_next;
      filtered_level <= level[COUNT_W-1:0];
      detector_mode  <= mode_next;
    end
  end

endmodule

>>> hdl/ehd_checker.sv
// ----------------------------------------------------------------------------
// ehd_checker
// Port-level checks for the EMA hit detector, bound to the top level.
// ----------------------------------------------------------------------------
module ehd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        hit,
  input logic [ehd_pkg::COUNT_W-1:0] filtered_level,
  input logic [ehd_pkg::MODE_W-1:0]  detector_mode
);
  import ehd_pkg::*;

  // A stalled result must hold until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit)
      && $stable(filtered_level) && $stable(detector_mode))
    else $error("stalled result changed");

  // A hit always leaves the detector armed.
  a_hit_armed: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> detector_mode == MODE_ARMED)
    else $error("hit without armed mode");

  // The input is stalled only while a finished result is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind ema_hit_detector_hysteresis_unit ehd_checker u_ehd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .hit            (hit),
  .filtered_level (filtered_level),
  .detector_mode  (detector_mode)
);

>>> bench/ema_hit_detector_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EMA hit detector checker
// Watches the sample, result and register channels of the hit detector. It
// keeps its own copy of the filter, the detector and the registers, and
// forecasts the result of every sample transfer. Each result transfer is
// compared field by field with the oldest forecast.
// ----------------------------------------------------------------------------
module ema_hit_detector_checker
  import ehd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [SAMPLE_WIDTH_DEF-1:0] sample,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  hit,
  input  logic [COUNT_W-1:0]    filtered_level,
  input  logic [MODE_W-1:0]     detector_mode,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int EMA_W = SAMPLE_WIDTH_DEF + EMA_FRAC_BITS_DEF;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] level;
    mode_t              mode;
  } detector_out_t;

  cfg_t                      regs;
  logic [EMA_W-1:0]          ema_q;
  mode_t                     mode_q;
  logic [HOLD_WIDTH_DEF-1:0] hold_q;
  detector_out_t             forecasts[$];
  int                        bad_count;

  task automatic report_mismatch(input string what, input int seen, input int wanted);
    bad_count++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, seen, wanted);
  endtask

  function automatic detector_out_t advance_detector(input logic [SAMPLE_WIDTH_DEF-1:0] raw);
    logic [9:0]         weight;
    logic [31:0]        acc;
    logic [COUNT_W-1:0] whole;
    detector_out_t      res;
    weight = (regs.alpha_q8 > ALPHA_ONE) ? 10'(ALPHA_ONE) : 10'(regs.alpha_q8);
    acc = 32'(weight) * (32'(raw) << EMA_FRAC_BITS_DEF)
        + (32'(ALPHA_ONE) - 32'(weight)) * 32'(ema_q)
        + (32'd1 << (ALPHA_SHIFT - 1));
    ema_q = EMA_W'(acc >> ALPHA_SHIFT);
    whole = ema_q[EMA_W-1 -: COUNT_W];
    res.hit = 1'b0;
    res.level = (whole > regs.baseline_counts) ? whole - regs.baseline_counts : '0;
    case (mode_q)
      MODE_ARMED: begin
        if (hold_q != '0) hold_q = hold_q - 1'b1;
        if (hold_q == '0 && res.level < regs.release_counts) mode_q = MODE_REFRACT;
      end
      MODE_REFRACT: mode_q = MODE_IDLE;
      default: begin
        if (res.level >= regs.fire_counts) begin
          res.hit = 1'b1;
          mode_q = MODE_ARMED;
          hold_q = regs.refractory_samples;
        end else begin
          mode_q = MODE_IDLE;
        end
      end
    endcase
    res.mode = mode_q;
    return res;
  endfunction

  always @(posedge clk) begin
    detector_out_t want;
    if (rst) begin
      regs = '{ALPHA_RESET, BASELINE_RESET, FIRE_RESET, RELEASE_RESET, REFRACT_RESET};
      ema_q = EMA_W'(BASELINE_RESET) << EMA_FRAC_BITS_DEF;
      mode_q = MODE_IDLE;
      hold_q = '0;
      forecasts.delete();
      bad_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (forecasts.size() == 0) begin
          report_mismatch("result with nothing pending", filtered_level, 0);
        end else begin
          want = forecasts.pop_front();
          if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
          if (filtered_level !== want.level)
            report_mismatch("filtered_level", filtered_level, want.level);
          if (detector_mode !== want.mode)
            report_mismatch("detector_mode", detector_mode, int'(want.mode));
        end
      end
      if (in_valid && !in_stall) forecasts.push_back(advance_detector(sample));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ALPHA:    regs.alpha_q8 = cfg_data[ALPHA_W-1:0];
          REG_BASELINE: regs.baseline_counts = cfg_data[COUNT_W-1:0];
          REG_FIRE:     regs.fire_counts = cfg_data[COUNT_W-1:0];
          REG_RELEASE:  regs.release_counts = cfg_data[COUNT_W-1:0];
          REG_REFRACT:  regs.refractory_samples = cfg_data[REFRACT_W-1:0];
          default: ;
        endcase
      end
    end
    mismatches <= bad_count;
    outstanding <= forecasts.size();
  end

endmodule

>>> bench/tb_ema_hit_detector_hysteresis_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EMA hit detector testbench
// Drives force samples and register writes into the hit detector, with
// random gaps on the sample side and random stalls on the result side. A
// short directed part walks the register extremes and the detector states;
// random phases then replay press events under random settings.
// ----------------------------------------------------------------------------
module tb_ema_hit_detector_hysteresis_unit;
  import ehd_pkg::*;

  localparam int SAMPLE_W = SAMPLE_WIDTH_DEF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
  localparam int RANDOM_SAMPLES = 420;
  localparam int PHASE_SAMPLES = 50;
  localparam int MAX_GAP = 6;
  localparam int SETTLE_CYCLES = 4;
  localparam int RUN_LIMIT_NS = 2_000_000;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  hit;
  logic [COUNT_W-1:0]    filtered_level;
  logic [MODE_W-1:0]     detector_mode;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    outstanding;
  bit                    brisk = 1'b0;
  int                    samples_sent = 0;

  ema_hit_detector_hysteresis_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall), .hit(hit),
    .filtered_level(filtered_level), .detector_mode(detector_mode),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ema_hit_detector_checker detect_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall), .hit(hit),
    .filtered_level(filtered_level), .detector_mode(detector_mode),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int draw_gap();
    return brisk ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [SAMPLE_W-1:0] clip_sample(input int v);
    if (v < 0) return '0;
    if (v > int'(SAMPLE_MAX)) return SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  task automatic push_sample(input logic [SAMPLE_W-1:0] value);
    int gap;
    @(negedge clk);
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= value;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Bits above a register's width are filled with noise, and one write goes
  // to an index that holds no register.
  task automatic load_settings(input cfg_t s);
    settle();
    write_reg(REG_ALPHA, {3'($urandom), s.alpha_q8});
    write_reg(REG_BASELINE, s.baseline_counts);
    write_reg(REG_FIRE, s.fire_counts);
    write_reg(REG_RELEASE, s.release_counts);
    write_reg(REG_REFRACT, {4'($urandom), s.refractory_samples});
    write_reg(CFG_IDX_W'(int'(REG_REFRACT) + $urandom_range(1, 3)), CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    case ($urandom_range(0, 9))
      0: s.alpha_q8 = '0;
      1: s.alpha_q8 = ALPHA_ONE;
      2: s.alpha_q8 = ALPHA_W'($urandom_range(257, 511));
      default: s.alpha_q8 = ALPHA_W'($urandom_range(16, 200));
    endcase
    s.baseline_counts = ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom)
                                                    : COUNT_W'($urandom_range(0, 1200));
    case ($urandom_range(0, 9))
      0: s.fire_counts = '0;
      1: s.fire_counts = COUNT_W'($urandom);
      default: s.fire_counts = COUNT_W'($urandom_range(30, 900));
    endcase
    s.release_counts = ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom)
                                                   : COUNT_W'($urandom_range(0, s.fire_counts));
    s.refractory_samples = ($urandom_range(0, 5) == 0) ? REFRACT_W'($urandom)
                                                       : REFRACT_W'($urandom_range(0, 12));
    return s;
  endfunction

  // A rest at baseline, a press that may or may not clear the fire
  // threshold, and a fall back to baseline long enough to release most times.
  task automatic press_event(input cfg_t s);
    int peak;
    peak = int'(s.baseline_counts) + int'(s.fire_counts) + $urandom_range(0, 460) - 60;
    repeat ($urandom_range(2, 10))
      push_sample(clip_sample(int'(s.baseline_counts) + $urandom_range(0, 40) - 20));
    repeat ($urandom_range(1, 8))
      push_sample(clip_sample(peak + $urandom_range(0, 40) - 20));
    repeat ($urandom_range(4, 24))
      push_sample(clip_sample(int'(s.baseline_counts) + $urandom_range(0, 40) - 20));
  endtask

  initial begin
    int gap;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      gap = draw_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    cfg_t s;
    int   goal;
    int   phase_goal;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    push_sample(SAMPLE_MAX);
    repeat (11) push_sample('0);

    s = '{ALPHA_ONE, COUNT_W'(0), COUNT_W'(4095), COUNT_W'(4095), REFRACT_W'(0)};
    load_settings(s);
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MAX);
    push_sample('0);
    push_sample('0);

    s = '{ALPHA_W'(511), COUNT_W'(4095), COUNT_W'(0), COUNT_W'(0), REFRACT_W'(255)};
    load_settings(s);
    push_sample('0);
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_W'(2048));

    s = '{ALPHA_W'(0), COUNT_W'(100), COUNT_W'(4095), COUNT_W'(4095), REFRACT_W'(0)};
    load_settings(s);
    push_sample(SAMPLE_MAX);
    push_sample('0);

    goal = samples_sent + RANDOM_SAMPLES;
    while (samples_sent < goal) begin
      s = random_settings();
      load_settings(s);
      brisk <= ($urandom_range(0, 3) == 0);
      phase_goal = samples_sent + PHASE_SAMPLES;
      while (samples_sent < phase_goal) begin
        if ($urandom_range(0, 4) != 0) begin
          press_event(s);
        end else begin
          repeat ($urandom_range(1, 6)) push_sample(SAMPLE_W'($urandom));
        end
      end
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
